/* design/dsi64_pkg.sv */
// Shared types and constants for the streaming decimal-to-integer parser.
// Used by the front, the token queue, the back and the top level.
package dsi64_pkg;

	localparam int VALUE_BITS_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int OUT_BITS        = 64;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Operations that the front hands to the back.
	typedef enum logic [1:0] {
		OP_DIGIT = 2'd0,
		OP_NEG   = 2'd1,
		OP_STRAY = 2'd2,
		OP_TERM  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
	} token_t;

endpackage

/* design/dsi64_front.sv */
// Front of the parser: accepts characters, tracks the lexical phase and
// turns digits, a minus sign, the first stray byte and NUL into tokens for the back. Depends on dsi64_pkg.
module dsi64_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          char_in,
	input  logic                q_ready,
	output logic                in_ready,
	output logic                push,
	output dsi64_pkg::token_t   tok
);

	typedef enum logic [2:0] {
		PH_SPACE  = 3'b001,
		PH_NUMBER = 3'b010,
		PH_SKIP   = 3'b100
	} phase_t;

	phase_t           phase_q;
	phase_t           phase_d;
	dsi64_pkg::op_t   op_d;
	logic             emit;
	logic             is_digit;
	logic             accept;

	assign in_ready  = q_ready;
	assign accept    = in_valid && q_ready;
	assign is_digit  = char_in inside {[dsi64_pkg::CH_ZERO:dsi64_pkg::CH_NINE]};
	assign tok       = {op_d, 4'(char_in - dsi64_pkg::CH_ZERO)};
	assign push      = accept && emit;

	always_comb begin
		phase_d = phase_q;
		emit    = 1'b0;
		op_d    = dsi64_pkg::OP_STRAY;
		if (char_in == dsi64_pkg::CH_NUL) begin
			phase_d = PH_SPACE;
			emit    = 1'b1;
			op_d    = dsi64_pkg::OP_TERM;
		end else begin
			case (phase_q)
				PH_SPACE: begin
					if (char_in inside {[dsi64_pkg::CH_TAB:dsi64_pkg::CH_CR],
						dsi64_pkg::CH_SPACE}) begin
						phase_d = PH_SPACE;
					end else if (char_in == dsi64_pkg::CH_MINUS) begin
						phase_d = PH_NUMBER;
						emit    = 1'b1;
						op_d    = dsi64_pkg::OP_NEG;
					end else if (char_in == dsi64_pkg::CH_PLUS) begin
						phase_d = PH_NUMBER;
					end else if (is_digit) begin
						phase_d = PH_NUMBER;
						emit    = 1'b1;
						op_d    = dsi64_pkg::OP_DIGIT;
					end else begin
						phase_d = PH_SKIP;
						emit    = 1'b1;
					end
				end
				PH_NUMBER: begin
					emit = 1'b1;
					if (is_digit) begin
						op_d = dsi64_pkg::OP_DIGIT;
					end else begin
						phase_d = PH_SKIP;
					end
				end
				default: begin
					phase_d = PH_SKIP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

endmodule

/* design/dsi64_queue.sv */
// Short token queue between the front and the back of the parser.
// Depends on dsi64_pkg for the token type.
module dsi64_queue #(
	parameter int DEPTH = dsi64_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dsi64_pkg::token_t push_tok,
	output logic              q_ready,
	input  logic              pop,
	output logic              q_valid,
	output dsi64_pkg::token_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dsi64_pkg::token_t mem [DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  count_q;

	assign q_ready = (count_q != CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/dsi64_back.sv */
// Back of the parser: runs the accumulator with an exact overflow check and
// holds the result in an output register. Depends on dsi64_pkg.
module dsi64_back #(
	parameter int VALUE_BITS = dsi64_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  dsi64_pkg::token_t                   head,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dsi64_pkg::OUT_BITS-1:0] value,
	output logic                                bad
);

	localparam int WIDE = VALUE_BITS + 4;

	logic [VALUE_BITS-1:0] acc_q;
	logic                  neg_q;
	logic                  err_q;
	logic                  out_valid_q;
	logic signed [dsi64_pkg::OUT_BITS-1:0] value_q;
	logic                  bad_q;

	logic [WIDE-1:0] acc_ext;
	logic [WIDE-1:0] times10;
	logic [WIDE-1:0] digit_ext;
	logic [WIDE-1:0] sum;
	logic [4:0]      sum_top;
	logic            ovf;

	// The result fits when the top bits of the widened sum are all sign copies.
	assign acc_ext   = {{4{acc_q[VALUE_BITS-1]}}, acc_q};
	assign times10   = (acc_ext << 3) + (acc_ext << 1);
	assign digit_ext = {{VALUE_BITS{1'b0}}, head.digit};
	assign sum       = neg_q ? times10 - digit_ext : times10 + digit_ext;
	assign sum_top   = sum[WIDE-1:VALUE_BITS-1];
	assign ovf       = !((sum_top == '0) || (sum_top == '1));

	assign pop       = q_valid && ((head.op != dsi64_pkg::OP_TERM) || !out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign bad       = bad_q;

	always_ff @(posedge clk) begin
		if (pop && head.op == dsi64_pkg::OP_TERM) begin
			value_q <= dsi64_pkg::OUT_BITS'($signed(acc_q));
			bad_q   <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			neg_q       <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.op == dsi64_pkg::OP_TERM) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (head.op)
					dsi64_pkg::OP_NEG: begin
						neg_q <= 1'b1;
					end
					dsi64_pkg::OP_DIGIT: begin
						// After an overflow the wrapped value stays put.
						if (!err_q) begin
							acc_q <= sum[VALUE_BITS-1:0];
							err_q <= ovf;
						end
					end
					dsi64_pkg::OP_STRAY: begin
						err_q <= 1'b1;
					end
					dsi64_pkg::OP_TERM: begin
						acc_q       <= '0;
						neg_q       <= 1'b0;
						err_q       <= 1'b0;
					end
					default: begin
						err_q <= 1'b1;
					end
				endcase
			end
		end
	end

endmodule

/* design/decimal_string_to_int64_unit.sv */
// Streaming signed decimal parser: one string byte per item, a NUL byte ends
// the number and yields one result item with the value and an error flag.
// The unit takes one byte every cycle while the queue has room; the front
// classifies each byte and a short token queue feeds the back, whose
// accumulator does one multiply-by-ten and add per cycle. The NUL token loads
// the output register when it is free. While a result waits on the output,
// the queue of QUEUE_DEPTH tokens keeps the input open until it fills.
module decimal_string_to_int64_unit #(
	parameter int VALUE_BITS  = dsi64_pkg::VALUE_BITS_DEF,
	parameter int QUEUE_DEPTH = dsi64_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            char_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dsi64_pkg::OUT_BITS-1:0] value,
	output logic                                  bad
);

	logic              q_ready;
	logic              push;
	dsi64_pkg::token_t push_tok;
	logic              pop;
	logic              q_valid;
	dsi64_pkg::token_t head;

	dsi64_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.char_in  (char_in),
		.q_ready  (q_ready),
		.in_ready (in_ready),
		.push     (push),
		.tok      (push_tok)
	);

	dsi64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.q_ready  (q_ready),
		.pop      (pop),
		.q_valid  (q_valid),
		.head     (head)
	);

	dsi64_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.bad       (bad)
	);

endmodule

/* design/dsi64_chk.sv */
// Port-level checks for the decimal parser, attached to the top level by bind.
// Depends on dsi64_pkg for the output width.
module dsi64_chk #(
	parameter int VALUE_BITS = dsi64_pkg::VALUE_BITS_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic [7:0]                            char_in,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [dsi64_pkg::OUT_BITS-1:0] value,
	input logic                                  bad
);

	// A waiting input item stays offered with the same byte.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(char_in))
		else $error("input item changed while stalled");

	// A held result item must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(bad))
		else $error("result item changed while stalled");

	// The queue only fills up behind a result that waits to be taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

	// The value is the sign extension of a VALUE_BITS-wide accumulator.
	a_sign_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((value >>> (VALUE_BITS - 1)) == 64'sd0) ||
			((value >>> (VALUE_BITS - 1)) == -64'sd1)))
		else $error("result value is not sign extended");

endmodule

bind decimal_string_to_int64_unit dsi64_chk #(.VALUE_BITS(VALUE_BITS)) u_chk (.*);
